// File: hw/rtl/sp_pkg.sv
// ----------------------------------------------------------------------------
// sp_pkg
// shared types and constants of the sandpile stabilizer
// ----------------------------------------------------------------------------
package sp_pkg;

  localparam int SideBits   = 6;
  localparam int Side       = 1 << SideBits;
  localparam int IdxBits    = 2 * SideBits;
  localparam int Cells      = Side * Side;
  localparam int StackDepth = 4096;
  localparam int TopBits    = $clog2(StackDepth + 1);
  localparam int StkIdxBits = $clog2(StackDepth);
  localparam int HBits      = 16;
  localparam int CntBits    = 13;
  localparam int TopplBits  = 48;
  localparam int DiamBits   = 7;
  localparam int InBits     = 24;
  localparam int OutBits    = 168;

  localparam logic [SideBits-1:0] Half = SideBits'(Side / 2);

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVER = 2'd1,
    STAT_FULL = 2'd2,
    STAT_OUT  = 2'd3
  } sp_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACC, ST_ACC_WR, ST_PUSH, ST_NEXT,
    ST_POP, ST_POP_WT, ST_TOP, ST_DONE
  } sp_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_ACC, OP_ACC_WR, OP_PUSH, OP_NEXT,
    OP_POP, OP_POP_WT, OP_TOP, OP_DONE
  } sp_op_e;

  typedef struct packed {
    sp_op_e op;
    logic   in_ready;
  } sp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_read;
    logic off_grid;
    logic n_zero;
    logic push_last;
    logic nb_more;
    logic stack_empty;
    logic topple;
    logic out_free;
  } sp_stat_t;

endpackage

// File: hw/rtl/sp_ctrl.sv
// ----------------------------------------------------------------------------
// sp_ctrl
// sequencer for clearing, reads, adds, pushes, pops and topplings
// ----------------------------------------------------------------------------
module sp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  sp_pkg::sp_stat_t stat_i,
  output sp_pkg::sp_cmd_t  cmd_o
);
  import sp_pkg::*;

  sp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = stat_i.in_read ? ST_DONE : ST_ACC_WR;
      ST_ACC:    state_d = stat_i.off_grid ? ST_NEXT : ST_ACC_WR;
      ST_ACC_WR: state_d = stat_i.n_zero ? ST_NEXT : ST_PUSH;
      ST_PUSH:   if (stat_i.push_last) state_d = ST_NEXT;
      ST_NEXT:   state_d = stat_i.nb_more ? ST_ACC : ST_POP;
      ST_POP:    state_d = stat_i.stack_empty ? ST_DONE : ST_POP_WT;
      ST_POP_WT: state_d = ST_TOP;
      ST_TOP:    state_d = stat_i.topple ? ST_ACC : ST_POP;
      ST_DONE:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = OP_NONE;
    unique case (state_q)
      ST_CLEAR:  cmd_o.op = OP_CLEAR;
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) cmd_o.op = OP_ACCEPT;
      end
      ST_ACC:    cmd_o.op = OP_ACC;
      ST_ACC_WR: cmd_o.op = OP_ACC_WR;
      ST_PUSH:   cmd_o.op = OP_PUSH;
      ST_NEXT:   cmd_o.op = OP_NEXT;
      ST_POP:    cmd_o.op = OP_POP;
      ST_POP_WT: cmd_o.op = OP_POP_WT;
      ST_TOP:    cmd_o.op = OP_TOP;
      ST_DONE:   cmd_o.op = OP_DONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/sp_datapath.sv
// ----------------------------------------------------------------------------
// sp_datapath
// grid and stack memories, statistics and the result register
// ----------------------------------------------------------------------------
module sp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sp_pkg::sp_cmd_t             cmd_i,
  output sp_pkg::sp_stat_t            stat_o,
  input  logic                        in_mode_i,
  input  logic [sp_pkg::SideBits-1:0] in_x_i,
  input  logic [sp_pkg::SideBits-1:0] in_y_i,
  input  logic [7:0]                  in_grains_i,
  input  logic                        cfg_wen_i,
  input  logic [sp_pkg::DiamBits-1:0] cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  out_status_o,
  output logic [sp_pkg::OutBits-1:0]  out_data_o
);
  import sp_pkg::*;

  localparam int CW = SideBits + 1;
  localparam int PushBits = HBits - 2;

  logic [HBits:0]      hmem [Cells];
  logic [IdxBits-1:0]  stk  [StackDepth];

  logic [HBits:0]      mem_rd_q;
  logic [IdxBits-1:0]  stk_rd_q;
  logic [IdxBits-1:0]  clr_q;
  logic                mode_q;
  logic [CW-1:0]       tx_q, ty_q;
  logic [7:0]          delta_q;
  logic [1:0]          nb_q;
  logic                in_nb_q;
  logic [IdxBits-1:0]  idx_q, pop_idx_q;
  logic [TopBits-1:0]  top_q;
  logic [PushBits-1:0] psh_q;
  logic [31:0]         sum_q;
  logic [CntBits-1:0]  cnt_q [5];
  logic [CntBits-1:0]  area_q;
  logic [TopplBits-1:0] topl_q;
  logic [SideBits-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [DiamBits-1:0] side_q, maxd_q;
  logic                over_q, full_q;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [OutBits-1:0]  out_data_q;

  // combinational helpers
  logic [HBits-1:0]    oldh, newh, toph;
  logic [HBits:0]      hsum;
  logic                was;
  logic [PushBits-1:0] npush;
  logic [2:0]          ko, kn, kt;
  logic [SideBits-1:0] cx, cy, nxmin, nxmax, nymin, nymax;
  logic                moved;
  logic [DiamBits-1:0] dx, dy, nside;
  logic [CW-1:0]       ntx, nty;
  logic [1:0]          nb_sel;
  logic                rd_out;
  logic [CntBits-1:0]  area_out;

  function automatic logic [2:0] cls(input logic [HBits-1:0] h);
    return (h < HBits'(4)) ? h[2:0] : 3'd4;
  endfunction

  assign oldh  = mem_rd_q[HBits-1:0];
  assign was   = mem_rd_q[HBits];
  assign hsum  = {1'b0, oldh} + (HBits+1)'(delta_q);
  assign newh  = hsum[HBits] ? {HBits{1'b1}} : hsum[HBits-1:0];
  assign npush = newh[HBits-1:2] - oldh[HBits-1:2];
  assign toph  = oldh - HBits'(4);
  assign ko    = cls(oldh);
  assign kn    = cls(newh);
  assign kt    = cls(toph);
  assign cx    = tx_q[SideBits-1:0];
  assign cy    = ty_q[SideBits-1:0];

  always_comb begin
    nxmin = xmin_q; nxmax = xmax_q; nymin = ymin_q; nymax = ymax_q;
    moved = 1'b0;
    if (cx < xmin_q) begin
      nxmin = cx; moved = 1'b1;
    end else if (cx > xmax_q) begin
      nxmax = cx; moved = 1'b1;
    end
    if (cy < ymin_q) begin
      nymin = cy; moved = 1'b1;
    end else if (cy > ymax_q) begin
      nymax = cy; moved = 1'b1;
    end
    dx = DiamBits'(nxmax - nxmin) + DiamBits'(1);
    dy = DiamBits'(nymax - nymin) + DiamBits'(1);
    nside = side_q;
    if (dx > nside) nside = dx;
    if (dy > nside) nside = dy;
  end

  // neighbor order: x+1, x-1, y+1, y-1
  assign nb_sel = (cmd_i.op == OP_TOP) ? 2'd0 : nb_q + 2'd1;
  always_comb begin
    logic [CW-1:0] px, py;
    px = {1'b0, pop_idx_q[IdxBits-1:SideBits]};
    py = {1'b0, pop_idx_q[SideBits-1:0]};
    ntx = px;
    nty = py;
    case (nb_sel)
      2'd0:    ntx = px + CW'(1);
      2'd1:    ntx = px - CW'(1);
      2'd2:    nty = py + CW'(1);
      default: nty = py - CW'(1);
    endcase
  end

  assign rd_out = (cx < xmin_q) || (cx > xmax_q) || (cy < ymin_q) || (cy > ymax_q);
  assign area_out = area_q;

  assign stat_o.clr_last    = &clr_q;
  assign stat_o.in_read     = in_mode_i;
  assign stat_o.off_grid    = tx_q[CW-1] | ty_q[CW-1];
  assign stat_o.n_zero      = (npush == '0);
  assign stat_o.push_last   = (psh_q == PushBits'(1));
  assign stat_o.nb_more     = in_nb_q && (nb_q != 2'd3);
  assign stat_o.stack_empty = (top_q == '0);
  assign stat_o.topple      = (oldh > HBits'(3));
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // grid memory
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CLEAR:
        hmem[clr_q] <= {(clr_q == {Half, Half}), {HBits{1'b0}}};
      OP_ACCEPT:
        mem_rd_q <= hmem[{in_x_i ^ Half, in_y_i ^ Half}];
      OP_ACC:
        mem_rd_q <= hmem[{tx_q[SideBits-1:0], ty_q[SideBits-1:0]}];
      OP_ACC_WR:
        hmem[idx_q] <= {1'b1, newh};
      OP_POP_WT:
        mem_rd_q <= hmem[stk_rd_q];
      OP_TOP:
        if (oldh > HBits'(3)) hmem[pop_idx_q] <= {1'b1, toph};
      default: ;
    endcase
  end

  // pending stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUSH && top_q < TopBits'(StackDepth)) begin
      stk[top_q[StkIdxBits-1:0]] <= idx_q;
    end
    if (cmd_i.op == OP_POP) begin
      stk_rd_q <= stk[StkIdxBits'(top_q - TopBits'(1))];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        mode_q  <= in_mode_i;
        tx_q    <= {1'b0, in_x_i ^ Half};
        ty_q    <= {1'b0, in_y_i ^ Half};
        delta_q <= in_grains_i;
        idx_q   <= {in_x_i ^ Half, in_y_i ^ Half};
      end
      OP_ACC:    idx_q <= {tx_q[SideBits-1:0], ty_q[SideBits-1:0]};
      OP_ACC_WR: psh_q <= npush;
      OP_PUSH:   psh_q <= psh_q - PushBits'(1);
      OP_NEXT: begin
        tx_q <= ntx;
        ty_q <= nty;
      end
      OP_POP_WT: pop_idx_q <= stk_rd_q;
      OP_TOP: begin
        tx_q    <= ntx;
        ty_q    <= nty;
        delta_q <= 8'd1;
      end
      default: ;
    endcase
  end

  // control and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      nb_q    <= '0;
      in_nb_q <= 1'b0;
      top_q   <= '0;
      sum_q   <= '0;
      for (int k = 0; k < 5; k++) cnt_q[k] <= (k == 0) ? CntBits'(1) : '0;
      area_q  <= CntBits'(1);
      topl_q  <= '0;
      xmin_q  <= Half;
      xmax_q  <= Half;
      ymin_q  <= Half;
      ymax_q  <= Half;
      side_q  <= DiamBits'(1);
      maxd_q  <= DiamBits'(Side);
      over_q  <= 1'b0;
      full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wen_i) maxd_q <= cfg_wdata_i;
      if (cmd_i.op == OP_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + IdxBits'(1);
        OP_ACCEPT: begin
          over_q  <= 1'b0;
          full_q  <= 1'b0;
          in_nb_q <= 1'b0;
        end
        OP_ACC: if (tx_q[CW-1] | ty_q[CW-1]) over_q <= 1'b1;
        OP_ACC_WR: begin
          for (int k = 0; k < 5; k++) begin
            cnt_q[k] <= cnt_q[k] + CntBits'(kn == 3'(k))
                        - CntBits'(was && ko == 3'(k));
          end
          sum_q <= sum_q + 32'(newh - oldh);
          if (!was) begin
            area_q <= area_q + CntBits'(1);
            xmin_q <= nxmin;
            xmax_q <= nxmax;
            ymin_q <= nymin;
            ymax_q <= nymax;
            if (moved) begin
              side_q <= nside;
              if (nside > maxd_q) over_q <= 1'b1;
            end
          end
        end
        OP_PUSH: begin
          if (top_q < TopBits'(StackDepth)) top_q <= top_q + TopBits'(1);
          else full_q <= 1'b1;
        end
        OP_NEXT: if (in_nb_q && nb_q != 2'd3) nb_q <= nb_q + 2'd1;
        OP_POP: if (top_q != '0) top_q <= top_q - TopBits'(1);
        OP_TOP: begin
          if (oldh > HBits'(3)) begin
            for (int k = 0; k < 5; k++) begin
              cnt_q[k] <= cnt_q[k] + CntBits'(kt == 3'(k))
                          - CntBits'(k == 4);
            end
            sum_q     <= sum_q - 32'd4;
            if (topl_q != {TopplBits{1'b1}}) topl_q <= topl_q + TopplBits'(1);
            in_nb_q   <= 1'b1;
            nb_q      <= 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DONE && (!out_valid_q || out_ready_i)) begin
      if (mode_q) begin
        out_status_q <= rd_out ? STAT_OUT : STAT_OK;
        out_data_q[15:0] <= rd_out ? 16'd0 : oldh;
      end else begin
        out_status_q <= full_q ? STAT_FULL : (over_q ? STAT_OVER : STAT_OK);
        out_data_q[15:0] <= 16'd0;
      end
      out_data_q[47:16]   <= sum_q;
      out_data_q[60:48]   <= cnt_q[0];
      out_data_q[73:61]   <= cnt_q[1];
      out_data_q[86:74]   <= cnt_q[2];
      out_data_q[99:87]   <= cnt_q[3];
      out_data_q[112:100] <= area_out;
      out_data_q[160:113] <= topl_q;
      out_data_q[167:161] <= side_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;

endmodule

// File: hw/rtl/sandpile_stabilizer.sv
// ----------------------------------------------------------------------------
// sandpile_stabilizer
// abelian sandpile on a 64 x 64 grid with stack-driven toppling
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tuser mode, tdata pos_x / pos_y / grains
// m_axis    out  tuser status, tdata height and grid statistics
// cfg       in   max_diameter, written on cfg_wen_i
//
// after reset a clearing pass over every grid cell runs before the first beat
// a read is accepted, looks up its cell and returns; an add writes its cell,
// pushes one stack entry per multiple of four crossed, then pops entries in
// turn; a popped cell above 3 topples, adding a grain to each neighbour on the grid
// one item at a time; a finished result may wait in the output register
// ----------------------------------------------------------------------------
module sandpile_stabilizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // pos_x[5:0], pos_y[11:6], grains[19:12]
  input  logic [sp_pkg::InBits-1:0] s_axis_tdata_i,
  // mode
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // cell_height, total_mass, zero/one/two/three_cells, touched_area,
  // toppling_total, extent
  output logic [sp_pkg::OutBits-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]                m_axis_tuser_o,
  input  logic                      cfg_wen_i,
  input  logic [sp_pkg::DiamBits-1:0] cfg_wdata_i
);
  import sp_pkg::*;

  sp_cmd_t  cmd;
  sp_stat_t stat;

  sp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_mode_i    (s_axis_tuser_i),
    .in_x_i       (s_axis_tdata_i[5:0]),
    .in_y_i       (s_axis_tdata_i[11:6]),
    .in_grains_i  (s_axis_tdata_i[19:12]),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_data_o   (m_axis_tdata_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule

// File: tb/sp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp_checker
// watches the sandpile stabilizer's channels, keeps its own copy of the grid,
// predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module sp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [sp_pkg::InBits-1:0]   s_axis_tdata_i,
  input  logic                        s_axis_tuser_i,
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [sp_pkg::OutBits-1:0]  m_axis_tdata_i,
  input  logic [1:0]                  m_axis_tuser_i,
  input  logic                        cfg_wen_i,
  input  logic [sp_pkg::DiamBits-1:0] cfg_wdata_i,
  output int                          errors_o,
  output int                          waiting_o,
  output int                          results_o,
  output longint                      topples_o
);
  import sp_pkg::*;

  localparam int          HalfSide = Side / 2;
  localparam int unsigned HMax     = (1 << HBits) - 1;
  localparam longint unsigned TopMax = (64'd1 << TopplBits) - 1;

  typedef struct packed {
    logic [DiamBits-1:0]  extent;
    logic [TopplBits-1:0] topples;
    logic [CntBits-1:0]   area;
    logic [CntBits-1:0]   three;
    logic [CntBits-1:0]   two;
    logic [CntBits-1:0]   one;
    logic [CntBits-1:0]   zero;
    logic [31:0]          mass;
    logic [HBits-1:0]     height;
  } grid_stats_t;

  typedef struct packed {
    sp_status_e  status;
    grid_stats_t stats;
  } grid_result_t;

  int unsigned     heights [Cells];
  bit              touched [Cells];
  int unsigned     stack [StackDepth];
  int unsigned     stack_top;
  longint unsigned grains;
  int unsigned     hist [5];
  longint unsigned topples;
  int              bnd [4];
  int              side_len;
  int unsigned     diam_limit;
  bit              hit_edge, hit_full;

  grid_result_t    expected_q [$];

  function automatic int unsigned height_class(int unsigned h);
    return (h < 4) ? h : 4;
  endfunction

  function automatic void clear_grid();
    foreach (heights[i]) begin
      heights[i] = 0;
      touched[i] = 0;
    end
    touched[HalfSide * Side + HalfSide] = 1;
    stack_top = 0;
    grains = 0;
    foreach (hist[i]) hist[i] = 0;
    hist[0] = 1;
    topples = 0;
    foreach (bnd[i]) bnd[i] = 0;
    side_len = 1;
    diam_limit = 64;
  endfunction

  function automatic void grow_bounds(int x, int y);
    bit moved;
    moved = 0;
    if (x < bnd[0]) begin
      bnd[0] = x; moved = 1;
    end else if (x > bnd[1]) begin
      bnd[1] = x; moved = 1;
    end
    if (y < bnd[2]) begin
      bnd[2] = y; moved = 1;
    end else if (y > bnd[3]) begin
      bnd[3] = y; moved = 1;
    end
    if (moved) begin
      if (bnd[1] - bnd[0] + 1 > side_len) side_len = bnd[1] - bnd[0] + 1;
      if (bnd[3] - bnd[2] + 1 > side_len) side_len = bnd[3] - bnd[2] + 1;
      if (side_len > diam_limit) hit_edge = 1;
    end
  endfunction

  function automatic void drop_grains(int x, int y, int unsigned delta);
    int unsigned idx, oldh, newh, n;
    if (x + HalfSide < 0 || x + HalfSide >= Side ||
        y + HalfSide < 0 || y + HalfSide >= Side) begin
      hit_edge = 1;
      return;
    end
    idx = (x + HalfSide) * Side + (y + HalfSide);
    if (!touched[idx]) begin
      touched[idx] = 1;
      hist[0]++;
      grow_bounds(x, y);
    end
    oldh = heights[idx];
    newh = (delta > HMax - oldh) ? HMax : oldh + delta;
    hist[height_class(oldh)]--;
    hist[height_class(newh)]++;
    heights[idx] = newh;
    grains += newh - oldh;
    for (n = newh / 4 - oldh / 4; n > 0; n--) begin
      if (stack_top < StackDepth) begin
        stack[stack_top] = idx;
        stack_top++;
      end else begin
        hit_full = 1;
      end
    end
  endfunction

  function automatic void topple_cell(int unsigned idx);
    int x, y;
    x = int'(idx / Side) - HalfSide;
    y = int'(idx % Side) - HalfSide;
    hist[height_class(heights[idx])]--;
    heights[idx] -= 4;
    hist[height_class(heights[idx])]++;
    grains -= 4;
    drop_grains(x + 1, y, 1);
    drop_grains(x - 1, y, 1);
    drop_grains(x, y + 1, 1);
    drop_grains(x, y - 1, 1);
    if (topples < TopMax) topples++;
  endfunction

  function automatic grid_result_t predict_beat(logic rd, logic [InBits-1:0] data);
    grid_result_t r;
    int x, y;
    int unsigned idx, area;
    x = int'($signed(data[5:0]));
    y = int'($signed(data[11:6]));
    r = '0;
    hit_edge = 0;
    hit_full = 0;
    if (rd) begin
      if (x < bnd[0] || x > bnd[1] || y < bnd[2] || y > bnd[3]) begin
        r.status = STAT_OUT;
      end else begin
        r.status = STAT_OK;
        r.stats.height = HBits'(heights[(x + HalfSide) * Side + (y + HalfSide)]);
      end
    end else begin
      drop_grains(x, y, int'(data[19:12]));
      while (stack_top > 0) begin
        stack_top--;
        idx = stack[stack_top];
        if (heights[idx] > 3) topple_cell(idx);
      end
      r.status = hit_full ? STAT_FULL : (hit_edge ? STAT_OVER : STAT_OK);
    end
    area = 0;
    foreach (hist[k]) area += hist[k];
    r.stats.mass    = grains[31:0];
    r.stats.zero    = CntBits'(hist[0]);
    r.stats.one     = CntBits'(hist[1]);
    r.stats.two     = CntBits'(hist[2]);
    r.stats.three   = CntBits'(hist[3]);
    r.stats.area    = CntBits'(area);
    r.stats.topples = TopplBits'(topples);
    r.stats.extent  = DiamBits'(side_len);
    return r;
  endfunction

  function automatic void check_beat(grid_result_t got);
    grid_result_t want;
    bit bad;
    want = expected_q.pop_front();
    bad = (got.status != want.status)
       || (got.stats.height  != want.stats.height)
       || (got.stats.mass    != want.stats.mass)
       || (got.stats.zero    != want.stats.zero)
       || (got.stats.one     != want.stats.one)
       || (got.stats.two     != want.stats.two)
       || (got.stats.three   != want.stats.three)
       || (got.stats.area    != want.stats.area)
       || (got.stats.topples != want.stats.topples)
       || (got.stats.extent  != want.stats.extent);
    if (bad) begin
      if (errors_o < 10) begin
        $display("mismatch at result %0d", results_o);
        $display("  exp st=%0d h=%0d m=%0d c=%0d/%0d/%0d/%0d a=%0d t=%0d e=%0d",
                 want.status, want.stats.height, want.stats.mass, want.stats.zero,
                 want.stats.one, want.stats.two, want.stats.three, want.stats.area,
                 want.stats.topples, want.stats.extent);
        $display("  got st=%0d h=%0d m=%0d c=%0d/%0d/%0d/%0d a=%0d t=%0d e=%0d",
                 got.status, got.stats.height, got.stats.mass, got.stats.zero,
                 got.stats.one, got.stats.two, got.stats.three, got.stats.area,
                 got.stats.topples, got.stats.extent);
      end
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_grid();
      expected_q.delete();
      errors_o  = 0;
      results_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("result beat with nothing expected");
          errors_o++;
        end else begin
          check_beat({sp_status_e'(m_axis_tuser_i), grid_stats_t'(m_axis_tdata_i)});
        end
        results_o++;
      end
      if (cfg_wen_i) diam_limit = int'(cfg_wdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(predict_beat(s_axis_tuser_i, s_axis_tdata_i));
    end
  end

  assign waiting_o = expected_q.size();
  assign topples_o = topples;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the sandpile stabilizer: directed corner and edge beats, then
// random adds and reads under three idle profiles and several diameter limits
// ----------------------------------------------------------------------------
module tb;
  import sp_pkg::*;

  localparam int StallLimit = 10000000;

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [InBits-1:0]    s_axis_tdata = '0;
  logic                 s_axis_tuser = 0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [OutBits-1:0]   m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_wen = 0;
  logic [DiamBits-1:0]  cfg_wdata = '0;

  int     errors, waiting, results;
  longint topples;
  int     send_idle, recv_idle;
  bit     recv_hold = 0;
  int     adds, reads;

  sandpile_stabilizer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata), .m_axis_tuser_o(m_axis_tuser),
    .cfg_wen_i(cfg_wen), .cfg_wdata_i(cfg_wdata)
  );

  sp_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata), .m_axis_tuser_i(m_axis_tuser),
    .cfg_wen_i(cfg_wen), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .waiting_o(waiting), .results_o(results), .topples_o(topples)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready = !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("timeout: no beat for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(logic rd, int x, int y, int g);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = rd;
    s_axis_tdata  = {4'b0, 8'(g), 6'(y), 6'(x)};
    if (rd) reads++; else adds++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set(int limit);
    s_axis_tvalid = 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (64) @(negedge clk_i);
    cfg_wen   = 1;
    cfg_wdata = DiamBits'(limit);
    @(negedge clk_i);
    cfg_wen   = 0;
  endtask

  task automatic random_phase(int n);
    int r, x, y, g;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        x = $urandom_range(8) - 4;
        y = $urandom_range(8) - 4;
      end else begin
        x = $urandom_range(63) - 32;
        y = $urandom_range(63) - 32;
      end
      r = $urandom_range(99);
      if (r < 76) g = $urandom_range(3);
      else if (r < 99) g = $urandom_range(15);
      else g = $urandom_range(255);
      if ($urandom_range(99) < 20) send_beat(1, x, y, $urandom_range(255));
      else send_beat(0, x, y, g);
    end
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    adds = 0;
    reads = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    drain_and_set(1);

    // directed
    send_beat(1, 0, 0, 0);
    send_beat(1, 5, 5, 0);
    send_beat(0, 0, 0, 0);
    send_beat(0, 1, 0, 0);
    send_beat(0, 0, 0, 3);
    send_beat(0, 0, 0, 1);
    send_beat(1, 1, 0, 255);
    send_beat(1, -1, 0, 0);
    send_beat(0, 31, 31, 4);
    send_beat(0, -32, -32, 7);
    send_beat(0, -32, 31, 3);
    send_beat(0, 31, -32, 8);
    send_beat(1, 31, 31, 0);
    send_beat(1, -32, -32, 0);
    send_beat(1, 31, -32, 0);
    send_beat(1, 10, 10, 0);
    send_beat(0, 0, 0, 255);
    send_beat(0, -21, 13, 170);
    send_beat(0, 11, -22, 85);
    send_beat(1, 0, 0, 0);
    send_beat(1, 0, 1, 0);

    drain_and_set(7);
    send_idle = 18;
    recv_idle = 46;
    random_phase(550);

    drain_and_set(64);
    send_idle = 46;
    recv_idle = 18;
    random_phase(550);

    drain_and_set(40);
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        recv_hold = 1;
        repeat (400) @(negedge clk_i);
        recv_hold = 0;
      end
      random_phase(550);
    join

    s_axis_tvalid = 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d adds and %0d reads sent, %0d results checked", adds, reads, results);
    $display("%0d topplings predicted, diameter limits 1, 7, 64 and 40", topples);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sp_pkg.sv
hw/rtl/sp_ctrl.sv
hw/rtl/sp_datapath.sv
hw/rtl/sandpile_stabilizer.sv
tb/sp_checker.sv
tb/tb.sv
